@@ rtl/ecb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ecb_pkg;

   localparam int QI     = 30;   // internal fraction bits
   localparam int ANG_W  = 16;
   localparam int CSR_W  = 16;
   localparam int OUT_W  = 16;
   localparam int XW     = 34;   // CORDIC x / y
   localparam int ZW     = 34;   // CORDIC residual angle
   localparam int VW     = 34;   // Q30 vector component
   localparam int SQ_W   = 64;   // sum of squares, wraps like a 64-bit word
   localparam int LEN_W  = 33;   // vector length
   localparam int DQ_W   = 32;   // quotient bits of the normalizing divide
   localparam int SQRT_STEPS = 32;
   localparam int WIDE_W = 96;   // scratch width for rounding
   localparam int DEGEN_LSBS = 4;

   localparam logic signed [XW-1:0] K_Q30 = 34'sd652032874;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      CSR_UP_X = 2'd0,
      CSR_UP_Y = 2'd1,
      CSR_UP_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 flip;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_lane_type;

   // round half away from zero, then shift right by n
   function automatic logic signed [WIDE_W-1:0] round_shift(
      input logic signed [WIDE_W-1:0] v, input int unsigned n);
      logic [WIDE_W-1:0] m;
      logic              neg;
      neg = v[WIDE_W-1];
      m   = neg ? WIDE_W'(-v) : WIDE_W'(v);
      if (n == 0) begin
         return v;
      end
      m = (m + (WIDE_W'(1) << (n - 1))) >> n;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [OUT_W-1:0] to_out(
      input logic signed [WIDE_W-1:0] v, input int unsigned n);
      logic signed [WIDE_W-1:0] r;
      r = round_shift(v, n);
      if (r > WIDE_W'(32767)) begin
         return 16'h7FFF;
      end
      if (r < -WIDE_W'(32768)) begin
         return 16'h8000;
      end
      return r[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/ecb_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ecb_cordic_cell import ecb_pkg::*; #(
   parameter int IDX = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            valid_in,
   input  wire cordic_lane_type lane_in  [2],
   output logic                 valid_out,
   output cordic_lane_type      lane_out [2]
);

   localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(ATAN_TAB[IDX % 32]));

   logic            valid_ff;
   cordic_lane_type lane_ff [2];
   cordic_lane_type lane_in_c [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         lane_in_c[l].flip = lane_in[l].flip;
         if (!lane_in[l].z[ZW-1]) begin
            lane_in_c[l].x = $signed(lane_in[l].x) - ($signed(lane_in[l].y) >>> IDX);
            lane_in_c[l].y = $signed(lane_in[l].y) + ($signed(lane_in[l].x) >>> IDX);
            lane_in_c[l].z = $signed(lane_in[l].z) - ATAN;
         end else begin
            lane_in_c[l].x = $signed(lane_in[l].x) + ($signed(lane_in[l].y) >>> IDX);
            lane_in_c[l].y = $signed(lane_in[l].y) - ($signed(lane_in[l].x) >>> IDX);
            lane_in_c[l].z = $signed(lane_in[l].z) + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;

endmodule

`default_nettype wire

@@ rtl/ecb_cross.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ecb_cross import ecb_pkg::*; #(
   parameter int AW = 34,
   parameter int BW = 34,
   parameter int OW = 35,
   parameter int SW = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [AW-1:0] a [3],
   input  wire logic signed [BW-1:0] b [3],
   input  wire logic [SW-1:0]        side_in,
   output logic                      out_valid,
   output logic signed [OW-1:0]      r [3],
   output logic [SW-1:0]             side_out
);

   localparam int PW = AW + BW;

   logic                 valid1_ff, valid2_ff;
   logic signed [PW-1:0] prod_in [6];
   logic signed [PW-1:0] prod_ff [6];
   logic [SW-1:0]        side1_ff, side2_ff;
   logic signed [PW:0]   diff  [3];
   logic signed [OW-1:0] r_in  [3];
   logic signed [OW-1:0] r_ff  [3];

   assign prod_in[0] = a[1] * b[2];
   assign prod_in[1] = a[2] * b[1];
   assign prod_in[2] = a[2] * b[0];
   assign prod_in[3] = a[0] * b[2];
   assign prod_in[4] = a[0] * b[1];
   assign prod_in[5] = a[1] * b[0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = (PW+1)'(prod_ff[2*k]) - (PW+1)'(prod_ff[2*k+1]);
         r_in[k] = OW'(round_shift(WIDE_W'(diff[k]), QI));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         side1_ff <= side_in;
         r_ff     <= r_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign r         = r_ff;
   assign side_out  = side2_ff;

endmodule

`default_nettype wire

@@ rtl/ecb_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ecb_sqrt_cell import ecb_pkg::*; #(
   parameter int IDX = 0,
   parameter int PW  = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            valid_in,
   input  wire logic [SQ_W-1:0] rem_in,
   input  wire logic [SQ_W-1:0] root_in,
   input  wire logic [PW-1:0]   pass_in,
   output logic                 valid_out,
   output logic [SQ_W-1:0]      rem_out,
   output logic [SQ_W-1:0]      root_out,
   output logic [PW-1:0]        pass_out
);

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * IDX);

   logic            valid_ff;
   logic [SQ_W-1:0] rem_ff, root_ff, rem_in_c, root_in_c, trial;
   logic [PW-1:0]   pass_ff;

   always_comb begin
      trial = root_in + BIT;
      if (rem_in >= trial) begin
         rem_in_c  = rem_in - trial;
         root_in_c = (root_in >> 1) + BIT;
      end else begin
         rem_in_c  = rem_in;
         root_in_c = root_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_c;
         root_ff <= root_in_c;
         pass_ff <= pass_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign pass_out  = pass_ff;

endmodule

`default_nettype wire

@@ rtl/ecb_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ecb_div_cell import ecb_pkg::*; #(
   parameter int IDX = 0,
   parameter int DW  = 66,
   parameter int PW  = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             valid_in,
   input  wire logic [LEN_W-1:0] len_in,
   input  wire logic [DW-1:0]    rem_in [3],
   input  wire logic [DQ_W-1:0]  q_in   [3],
   input  wire logic [PW-1:0]    pass_in,
   output logic                  valid_out,
   output logic [LEN_W-1:0]      len_out,
   output logic [DW-1:0]         rem_out [3],
   output logic [DQ_W-1:0]       q_out   [3],
   output logic [PW-1:0]         pass_out
);

   localparam int BITPOS = DQ_W - 1 - IDX;

   logic             valid_ff;
   logic [LEN_W-1:0] len_ff;
   logic [DW-1:0]    dv;
   logic [DW-1:0]    rem_in_c [3];
   logic [DW-1:0]    rem_ff   [3];
   logic [DQ_W-1:0]  q_in_c   [3];
   logic [DQ_W-1:0]  q_ff     [3];
   logic [PW-1:0]    pass_ff;

   assign dv = DW'(len_in) << BITPOS;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rem_in_c[k] = rem_in[k];
         q_in_c[k]   = q_in[k];
         if (rem_in[k] >= dv) begin
            rem_in_c[k]       = rem_in[k] - dv;
            q_in_c[k][BITPOS] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff  <= len_in;
         rem_ff  <= rem_in_c;
         q_ff    <= q_in_c;
         pass_ff <= pass_in;
      end
   end

   assign valid_out = valid_ff;
   assign len_out   = len_ff;
   assign rem_out   = rem_ff;
   assign q_out     = q_ff;
   assign pass_out  = pass_ff;

endmodule

`default_nettype wire

@@ rtl/ecb_norm.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Unit vector: squares, sum, bit-per-cell square root, bit-per-cell divide.
module ecb_norm import ecb_pkg::*; #(
   parameter int IW        = 35,
   parameter int SW        = 8,
   parameter int DEGEN_MIN = 262144
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [IW-1:0] v [3],
   input  wire logic [SW-1:0]        side_in,
   output logic                      out_valid,
   output logic                      ok,
   output logic signed [VW-1:0]      u [3],
   output logic [SW-1:0]             side_out
);

   localparam int DW0 = IW + QI + 1;
   localparam int DW  = (DW0 > LEN_W + DQ_W) ? DW0 : LEN_W + DQ_W;
   localparam int SPW = 3 + 3 * IW + SW;   // carried through the root cells
   localparam int DPW = 3 + 1 + SW;        // carried through the divide cells

   logic              valid1_ff, valid2_ff, valid_o_ff;
   logic [2:0]        sg_in;
   logic [IW-1:0]     mg_in [3];
   logic [SQ_W-1:0]   sq_in [3];
   logic [2:0]        sg1_ff;
   logic [IW-1:0]     mg1_ff [3];
   logic [SQ_W-1:0]   sq1_ff [3];
   logic [SW-1:0]     side1_ff;
   logic [SQ_W-1:0]   sum_ff;
   logic [SPW-1:0]    spass2_ff;

   logic [SQRT_STEPS:0] s_valid_w;
   logic [SQ_W-1:0]     s_rem_w  [SQRT_STEPS+1];
   logic [SQ_W-1:0]     s_root_w [SQRT_STEPS+1];
   logic [SPW-1:0]      s_pass_w [SQRT_STEPS+1];

   logic [LEN_W-1:0] len;
   logic             len_ok;
   logic [2:0]       sg_s;
   logic [IW-1:0]    mg_s [3];
   logic [SW-1:0]    side_s;

   logic [DQ_W:0]    d_valid_w;
   logic [LEN_W-1:0] d_len_w  [DQ_W+1];
   logic [DW-1:0]    d_rem_w  [DQ_W+1][3];
   logic [DQ_W-1:0]  d_q_w    [DQ_W+1][3];
   logic [DPW-1:0]   d_pass_w [DQ_W+1];

   logic               ok_ff;
   logic signed [VW-1:0] u_in [3];
   logic signed [VW-1:0] u_ff [3];
   logic [SW-1:0]      side_o_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sg_in[k] = v[k][IW-1];
         mg_in[k] = sg_in[k] ? IW'(-v[k]) : IW'(v[k]);
         sq_in[k] = SQ_W'(mg_in[k] * mg_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff  <= 1'b0;
         valid2_ff  <= 1'b0;
         valid_o_ff <= 1'b0;
      end else if (en) begin
         valid1_ff  <= in_valid;
         valid2_ff  <= valid1_ff;
         valid_o_ff <= d_valid_w[DQ_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sg1_ff    <= sg_in;
         mg1_ff    <= mg_in;
         sq1_ff    <= sq_in;
         side1_ff  <= side_in;
         sum_ff    <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
         spass2_ff <= {sg1_ff, mg1_ff[0], mg1_ff[1], mg1_ff[2], side1_ff};
      end
   end

   assign s_valid_w[0] = valid2_ff;
   assign s_rem_w[0]   = sum_ff;
   assign s_root_w[0]  = '0;
   assign s_pass_w[0]  = spass2_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      ecb_sqrt_cell #(.IDX(i), .PW(SPW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (s_valid_w[i]),
         .rem_in   (s_rem_w[i]),
         .root_in  (s_root_w[i]),
         .pass_in  (s_pass_w[i]),
         .valid_out(s_valid_w[i+1]),
         .rem_out  (s_rem_w[i+1]),
         .root_out (s_root_w[i+1]),
         .pass_out (s_pass_w[i+1])
      );
   end

   assign len    = s_root_w[SQRT_STEPS][LEN_W-1:0];
   assign len_ok = (len >= LEN_W'(DEGEN_MIN));
   assign {sg_s, mg_s[0], mg_s[1], mg_s[2], side_s} = s_pass_w[SQRT_STEPS];

   assign d_valid_w[0] = s_valid_w[SQRT_STEPS];
   assign d_len_w[0]   = len;
   assign d_pass_w[0]  = {sg_s, len_ok, side_s};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_rem_w[0][k] = (DW'(mg_s[k]) << QI) + DW'(len >> 1);
         d_q_w[0][k]   = '0;
      end
   end

   for (genvar i = 0; i < DQ_W; i++) begin : g_div
      ecb_div_cell #(.IDX(i), .DW(DW), .PW(DPW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (d_valid_w[i]),
         .len_in   (d_len_w[i]),
         .rem_in   (d_rem_w[i]),
         .q_in     (d_q_w[i]),
         .pass_in  (d_pass_w[i]),
         .valid_out(d_valid_w[i+1]),
         .len_out  (d_len_w[i+1]),
         .rem_out  (d_rem_w[i+1]),
         .q_out    (d_q_w[i+1]),
         .pass_out (d_pass_w[i+1])
      );
   end

   // sign of component k sits just above the length flag
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = d_pass_w[DQ_W][SW+1+k]
                 ? -$signed(VW'(d_q_w[DQ_W][k])) : $signed(VW'(d_q_w[DQ_W][k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff      <= u_in;
         ok_ff     <= d_pass_w[DQ_W][SW];
         side_o_ff <= d_pass_w[DQ_W][SW-1:0];
      end
   end

   assign out_valid = valid_o_ff;
   assign ok        = ok_ff;
   assign u         = u_ff;
   assign side_out  = side_o_ff;

endmodule

`default_nettype wire

@@ rtl/euler_angles_to_camera_basis_core.sv @@
// Camera basis from yaw and pitch.
// Input channel req_: yaw and pitch in binary angle units (65536 = one turn).
// Result channel rsp_: front, right and up unit vectors in signed fixed point
// with FRAC_BITS fraction bits, plus a degenerate flag when front is parallel
// to the world-up vector (right and up then read zero).
// Configuration port csr_: world-up x/y/z at indexes 0..2, written while idle.
// Each transaction yields exactly one result transaction.
// Throughput: one transaction per cycle while rsp_stall holds no result, set
// by a fully pipelined datapath: a chain of CORDIC cells, two cross-product
// stages, and two normalizers that each run a 32-cell root chain and a
// 32-cell divide chain. All stages advance together; when rsp_valid is high
// and rsp_stall is held, the whole pipeline freezes, the result holds, and
// req_stall rises in the same cycle. Reset empties the pipeline and loads
// world-up = (0, 1, 0).
`timescale 1ns / 1ps
`default_nettype none

module euler_angles_to_camera_basis_core import ecb_pkg::*; #(
   parameter int FRAC_BITS     = 14,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [ANG_W-1:0]        req_yaw_angle,
   input  wire logic signed [ANG_W-1:0] req_pitch_angle,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_front_x,
   output logic signed [OUT_W-1:0]      rsp_front_y,
   output logic signed [OUT_W-1:0]      rsp_front_z,
   output logic signed [OUT_W-1:0]      rsp_right_x,
   output logic signed [OUT_W-1:0]      rsp_right_y,
   output logic signed [OUT_W-1:0]      rsp_right_z,
   output logic signed [OUT_W-1:0]      rsp_up_x,
   output logic signed [OUT_W-1:0]      rsp_up_y,
   output logic signed [OUT_W-1:0]      rsp_up_z,
   output logic                         rsp_degenerate,
   input  wire logic                    csr_write_enable,
   input  wire logic [1:0]              csr_index,
   input  wire logic [CSR_W-1:0]        csr_write_data
);

   localparam int SH        = QI - FRAC_BITS;
   localparam int WW        = CSR_W + SH;
   localparam int RW        = SH + 19;     // cross-product result width
   localparam int DEGEN_MIN = DEGEN_LSBS << SH;
   localparam int F_W       = 3 * VW;

   logic en;

   // configuration
   logic signed [CSR_W-1:0] up_x_ff, up_y_ff, up_z_ff;
   logic signed [WW-1:0]    w [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= '0;
         up_y_ff <= CSR_W'(16384);
         up_z_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_UP_X: up_x_ff <= csr_write_data;
            CSR_UP_Y: up_y_ff <= csr_write_data;
            CSR_UP_Z: up_z_ff <= csr_write_data;
            default:  ;
         endcase
      end
   end

   assign w[0] = WW'(up_x_ff) <<< SH;
   assign w[1] = WW'(up_y_ff) <<< SH;
   assign w[2] = WW'(up_z_ff) <<< SH;

   // global advance: the pipeline moves unless a finished result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // CORDIC entry: fold the half turn around 180 degrees onto the right half
   function automatic cordic_lane_type lane_start(input logic [ANG_W-1:0] ang);
      cordic_lane_type l;
      logic [31:0]     a;
      a      = {ang, 16'h0000};
      l.flip = a[31] ^ a[30];
      l.x    = K_Q30;
      l.y    = '0;
      l.z    = ZW'($signed({a[31] ^ l.flip, a[30:0]}));
      return l;
   endfunction

   cordic_lane_type            lane_w [CORDIC_STAGES+1][2];
   logic [CORDIC_STAGES:0]     cvalid_w;

   assign cvalid_w[0]  = req_valid;
   assign lane_w[0][0] = lane_start(req_yaw_angle);
   assign lane_w[0][1] = lane_start(req_pitch_angle);

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      ecb_cordic_cell #(.IDX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .valid_in (cvalid_w[i]),
         .lane_in  (lane_w[i]),
         .valid_out(cvalid_w[i+1]),
         .lane_out (lane_w[i+1])
      );
   end

   // front vector: cos/sin products, then rounding
   logic signed [XW-1:0]   cs [2];
   logic signed [XW-1:0]   sn [2];
   logic                   va_ff, vb_ff;
   logic signed [2*XW-1:0] fx_prod_ff, fz_prod_ff;
   logic signed [XW-1:0]   sp_ff;
   logic signed [VW-1:0]   f_ff [3];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         cs[l] = lane_w[CORDIC_STAGES][l].flip ? -lane_w[CORDIC_STAGES][l].x
                                               : lane_w[CORDIC_STAGES][l].x;
         sn[l] = lane_w[CORDIC_STAGES][l].flip ? -lane_w[CORDIC_STAGES][l].y
                                               : lane_w[CORDIC_STAGES][l].y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= cvalid_w[CORDIC_STAGES];
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_prod_ff <= cs[0] * cs[1];
         fz_prod_ff <= sn[0] * cs[1];
         sp_ff      <= sn[1];
         f_ff[0]    <= VW'(round_shift(WIDE_W'(fx_prod_ff), QI));
         f_ff[1]    <= VW'(sp_ff);
         f_ff[2]    <= VW'(round_shift(WIDE_W'(fz_prod_ff), QI));
      end
   end

   // right = normalize(front x world_up)
   logic                 c1_valid;
   logic signed [RW-1:0] r1 [3];
   logic [F_W-1:0]       c1_side;
   logic                 n1_valid, n1_ok;
   logic signed [VW-1:0] ru [3];
   logic [F_W-1:0]       n1_side;
   logic signed [VW-1:0] f_n1 [3];

   ecb_cross #(.AW(VW), .BW(WW), .OW(RW), .SW(F_W)) u_cross_right (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (vb_ff),
      .a        (f_ff),
      .b        (w),
      .side_in  ({f_ff[0], f_ff[1], f_ff[2]}),
      .out_valid(c1_valid),
      .r        (r1),
      .side_out (c1_side)
   );

   ecb_norm #(.IW(RW), .SW(F_W), .DEGEN_MIN(DEGEN_MIN)) u_norm_right (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c1_valid),
      .v        (r1),
      .side_in  (c1_side),
      .out_valid(n1_valid),
      .ok       (n1_ok),
      .u        (ru),
      .side_out (n1_side)
   );

   assign {f_n1[0], f_n1[1], f_n1[2]} = n1_side;

   // up = normalize(right x front)
   localparam int S2_W = 1 + 2 * F_W;

   logic                 c2_valid;
   logic signed [RW-1:0] u2 [3];
   logic [S2_W-1:0]      c2_side;
   logic                 n2_valid, n2_ok;
   logic signed [VW-1:0] uu [3];
   logic [S2_W-1:0]      n2_side;
   logic                 ok1_o;
   logic signed [VW-1:0] ru_o [3];
   logic signed [VW-1:0] f_o  [3];

   ecb_cross #(.AW(VW), .BW(VW), .OW(RW), .SW(S2_W)) u_cross_up (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (n1_valid),
      .a        (ru),
      .b        (f_n1),
      .side_in  ({n1_ok, ru[0], ru[1], ru[2], n1_side}),
      .out_valid(c2_valid),
      .r        (u2),
      .side_out (c2_side)
   );

   ecb_norm #(.IW(RW), .SW(S2_W), .DEGEN_MIN(DEGEN_MIN)) u_norm_up (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c2_valid),
      .v        (u2),
      .side_in  (c2_side),
      .out_valid(n2_valid),
      .ok       (n2_ok),
      .u        (uu),
      .side_out (n2_side)
   );

   assign {ok1_o, ru_o[0], ru_o[1], ru_o[2], f_o[0], f_o[1], f_o[2]} = n2_side;

   // output register
   logic                    out_valid_ff;
   logic                    degen_ff;
   logic                    ok_all;
   logic signed [OUT_W-1:0] front_ff [3];
   logic signed [OUT_W-1:0] right_ff [3];
   logic signed [OUT_W-1:0] upv_ff   [3];

   assign ok_all = ok1_o && n2_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= n2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= !ok_all;
         for (int k = 0; k < 3; k++) begin
            front_ff[k] <= to_out(WIDE_W'(f_o[k]), SH);
            right_ff[k] <= ok_all ? to_out(WIDE_W'(ru_o[k]), SH) : '0;
            upv_ff[k]   <= ok_all ? to_out(WIDE_W'(uu[k]), SH) : '0;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_degenerate = degen_ff;
   assign rsp_front_x    = front_ff[0];
   assign rsp_front_y    = front_ff[1];
   assign rsp_front_z    = front_ff[2];
   assign rsp_right_x    = right_ff[0];
   assign rsp_right_y    = right_ff[1];
   assign rsp_right_z    = right_ff[2];
   assign rsp_up_x       = upv_ff[0];
   assign rsp_up_y       = upv_ff[1];
   assign rsp_up_z       = upv_ff[2];

   // a degenerate transaction carries zero right and up vectors
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_right_x == '0 && rsp_right_y == '0 &&
         rsp_right_z == '0 && rsp_up_x == '0 && rsp_up_y == '0 && rsp_up_z == '0)
      else $error("degenerate result with nonzero right/up");

   // the pipeline comes out of reset empty
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a held result freezes the CORDIC chain too
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(cvalid_w[CORDIC_STAGES:1]))
      else $error("CORDIC chain moved during output stall");

   // input is refused only while rsp_valid is high
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no held result");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import ecb_pkg::*;

   localparam int FRAC       = 14;
   localparam int STAGES     = 16;
   localparam int LATENCY    = STAGES + 141;
   localparam int HOLD_LEN   = 400;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [1:0] CSR_SPARE = 2'd3;   // no register behind this index

   typedef struct {
      logic [OUT_W-1:0] comp[9];
      logic             degen;
   } basis_type;

   class basis_board;
      longint world_up[3];
      basis_type pending_basis[$];
      int     errors;
      string  comp_name[9] = '{"front_x", "front_y", "front_z", "right_x", "right_y",
                               "right_z", "up_x", "up_y", "up_z"};

      function new();
         world_up = '{0, 16384, 0};
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         if (idx <= CSR_UP_Z) world_up[idx] = longint'($signed(val));
      endfunction

      function longint rnd_shift(longint v, int n);
         longint unsigned m;
         if (n == 0) return v;
         m = (v < 0) ? longint'(-v) : v;
         m = (m + (64'd1 << (n - 1))) >> n;
         return (v < 0) ? -longint'(m) : longint'(m);
      endfunction

      function void rotate(logic [15:0] ang, output longint c, output longint s);
         logic [31:0] a;
         logic        flip;
         longint      x, y, z, nx;
         a = {ang, 16'h0};
         flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
         if (flip) a = a - 32'h80000000;
         z = longint'($signed(a));
         x = longint'(K_Q30);
         y = 0;
         for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - longint'(ATAN_TAB[i]);
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + longint'(ATAN_TAB[i]);
            end
            x = nx;
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function void cross3(longint a[3], longint b[3], output longint r[3]);
         r[0] = rnd_shift(a[1] * b[2] - a[2] * b[1], QI);
         r[1] = rnd_shift(a[2] * b[0] - a[0] * b[2], QI);
         r[2] = rnd_shift(a[0] * b[1] - a[1] * b[0], QI);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function bit unit_vec(longint v[3], output longint u[3]);
         longint unsigned sum, len, m, q;
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            m = (v[k] < 0) ? longint'(-v[k]) : v[k];
            sum = sum + m * m;
         end
         len = int_sqrt(sum);
         if (len < (longint'(DEGEN_LSBS) << (QI - FRAC)) || len == 0) return 0;
         for (int k = 0; k < 3; k++) begin
            m = (v[k] < 0) ? longint'(-v[k]) : v[k];
            q = ((m << QI) + len / 2) / len;
            u[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
         end
         return 1;
      endfunction

      function logic [15:0] to_q14(longint v);
         longint r;
         r = rnd_shift(v, QI - FRAC);
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r[15:0];
      endfunction

      function void note_input(logic [15:0] yaw, logic [15:0] pitch);
         longint cy, sy, cp, sp;
         longint f[3], w[3], r[3], ru[3], u[3], uu[3];
         bit     ok;
         basis_type b;
         rotate(yaw, cy, sy);
         rotate(pitch, cp, sp);
         f[0] = rnd_shift(cy * cp, QI);
         f[1] = sp;
         f[2] = rnd_shift(sy * cp, QI);
         for (int k = 0; k < 3; k++) w[k] = world_up[k] <<< (QI - FRAC);
         cross3(f, w, r);
         ok = unit_vec(r, ru);
         if (ok) begin
            cross3(ru, f, u);
            ok = unit_vec(u, uu);
         end
         for (int k = 0; k < 3; k++) begin
            b.comp[k]     = to_q14(f[k]);
            b.comp[3 + k] = ok ? to_q14(ru[k]) : '0;
            b.comp[6 + k] = ok ? to_q14(uu[k]) : '0;
         end
         b.degen = !ok;
         pending_basis.push_back(b);
      endfunction

      function void report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endfunction

      function void check_result(basis_type got);
         basis_type exp_b;
         if (pending_basis.size() == 0) begin
            report("result transaction with nothing outstanding");
            return;
         end
         exp_b = pending_basis.pop_front();
         for (int k = 0; k < 9; k++)
            if (got.comp[k] !== exp_b.comp[k])
               report($sformatf("%s got %0d want %0d", comp_name[k],
                  $signed(got.comp[k]), $signed(exp_b.comp[k])));
         if (got.degen !== exp_b.degen)
            report($sformatf("degenerate got %0b want %0b", got.degen, exp_b.degen));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_yaw_angle = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_front_x, rsp_front_y, rsp_front_z;
   logic signed [15:0] rsp_right_x, rsp_right_y, rsp_right_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;
   logic rsp_degenerate;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;

   basis_board board = new();
   bit quiet = 0;        // no idling on either side
   bit hold_req = 0;
   int idle_cycles = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   euler_angles_to_camera_basis_core #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_yaw_angle(req_yaw_angle), .req_pitch_angle(req_pitch_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_front_x(rsp_front_x), .rsp_front_y(rsp_front_y), .rsp_front_z(rsp_front_z),
      .rsp_right_x(rsp_right_x), .rsp_right_y(rsp_right_y), .rsp_right_z(rsp_right_z),
      .rsp_up_x(rsp_up_x), .rsp_up_y(rsp_up_y), .rsp_up_z(rsp_up_z),
      .rsp_degenerate(rsp_degenerate),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("euler_angles_to_camera_basis_core: mismatch");
         $finish;
      end
   end

   // receiver: checks each result transaction, then stalls a random while (one long hold on hold_req)
   initial begin
      basis_type got;
      int left;
      left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.comp = '{rsp_front_x, rsp_front_y, rsp_front_z, rsp_right_x, rsp_right_y,
                         rsp_right_z, rsp_up_x, rsp_up_y, rsp_up_z};
            got.degen = rsp_degenerate;
            board.check_result(got);
            left = quiet ? 0 : $urandom_range(0, 3);
         end else if (left > 0) begin
            left--;
         end
         if (hold_req) begin
            hold_req = 0;
            rsp_stall <= 1;
            repeat (HOLD_LEN) @(posedge clock);
            rsp_stall <= 0;
            left = 0;
         end else begin
            rsp_stall <= (left > 0);
         end
      end
   end

   task automatic send(logic [15:0] yaw, logic [15:0] pitch);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_yaw_angle <= yaw;
      req_pitch_angle <= pitch;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      board.note_input(yaw, pitch);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending_basis.size() > 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      csr_write_enable <= 0;
   endtask

   task automatic set_world_up(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      write_reg(CSR_UP_X, x);
      write_reg(CSR_UP_Y, y);
      write_reg(CSR_UP_Z, z);
      write_reg(CSR_SPARE, 16'($urandom));
   endtask

   function automatic logic [15:0] in_range();
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic random_items(int count);
      logic [15:0] yaw, pitch;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         yaw = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3) << 14) : 16'($urandom);
         if (pick < 80) pitch = in_range();
         else if (pick < 92) pitch = 16'($urandom);
         else pitch = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         send(yaw, pitch);
      end
   endtask

   logic [15:0] dir_yaw[] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000,
                              16'h0001, 16'h7FFF, 16'h8001, 16'h3FFF, 16'hBFFF, 16'h1234};
   logic [15:0] dir_pitch[] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h3FFF,
                                16'hC001, 16'h2000, 16'hE000, 16'hFFFF, 16'h0001, 16'h6000};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_world_up(16'd0, 16'd16384, 16'd0);
      quiet = 1;
      foreach (dir_yaw[i]) send(dir_yaw[i], dir_pitch[i]);
      foreach (dir_pitch[i]) send(dir_yaw[(i + 5) % dir_yaw.size()], dir_pitch[i]);
      quiet = 0;
      drain();

      // zero world-up: every transaction is degenerate
      set_world_up(16'd0, 16'd0, 16'd0);
      send(16'h1000, 16'h0000);
      send(16'hFFFF, 16'h4000);
      random_items(100);
      drain();

      // receiver holds off long enough for the pipeline to back up
      set_world_up(16'sd16384, 16'sd16384, 16'sd16384);
      hold_req = 1;
      random_items(350);
      drain();

      set_world_up(-16'sd16384, -16'sd16384, -16'sd16384);
      random_items(300);
      drain();

      set_world_up(-16'sd16384, 16'd0, 16'd0);
      quiet = 1;
      random_items(250);
      quiet = 0;
      drain();

      set_world_up(16'd0, -16'sd16384, 16'sd16384);
      random_items(300);
      drain();

      for (int p = 0; p < 3; p++) begin
         set_world_up(in_range(), in_range(), in_range());
         random_items(220);
         drain();
      end

      repeat (LATENCY + 40) @(posedge clock);
      if (board.errors == 0 && board.pending_basis.size() == 0) begin
         $display("euler_angles_to_camera_basis_core: match");
      end else begin
         $display("euler_angles_to_camera_basis_core: mismatch");
      end
      $finish;
   end

endmodule
